/* src/fwq_pkg.sv */
`default_nettype none
package fwq_pkg;
    localparam int WAITERS  = 16;
    localparam int BUCKETS  = 64;
    localparam int ID_W     = $clog2(WAITERS);
    localparam int LINK_W   = $clog2(WAITERS + 1);
    localparam int BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int HASH_SHIFT = 14;

    localparam logic [LINK_W-1:0] EMPTY = LINK_W'(WAITERS);

    localparam logic [6:0]  OP_MASK        = 7'h7F;
    localparam logic [6:0]  OP_WAIT        = 7'd0;
    localparam logic [6:0]  OP_WAKE        = 7'd1;
    localparam logic [6:0]  OP_WAIT_MASKED = 7'd9;
    localparam logic [6:0]  OP_WAKE_MASKED = 7'd10;
    localparam logic [31:0] MATCH_ANY      = 32'hFFFF_FFFF;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_FAULT    = 3'd2;
    localparam logic [2:0] ST_AGAIN    = 3'd3;
    localparam logic [2:0] ST_TIMEDOUT = 3'd4;
    localparam logic [2:0] ST_NOSYS    = 3'd5;
    localparam logic [2:0] ST_QUEUED   = 3'd6;
    localparam logic [2:0] ST_BUSY     = 3'd7;

    // slot memory write request
    typedef struct packed {
        logic              we_full;
        logic              we_link;
        logic [ID_W-1:0]   idx;
        logic [63:0]       address;
        logic [31:0]       mask;
        logic [LINK_W-1:0] link;
    } t_slot_wr;

    // slot memory read data
    typedef struct packed {
        logic [63:0]       address;
        logic [31:0]       mask;
        logic [LINK_W-1:0] link;
    } t_slot_rd;

    // bucket head memory write request
    typedef struct packed {
        logic              we;
        logic [BKT_W-1:0]  idx;
        logic [LINK_W-1:0] head;
    } t_bkt_wr;

    // bucket index from the futex address
    function automatic logic [BKT_W-1:0] bucket_of(input logic [63:0] a);
        logic [31:0] h;
        h = 32'((a >> 2) ^ (a >> HASH_SHIFT));
        return BKT_W'(h % BUCKETS);
    endfunction
endpackage
`default_nettype wire

/* src/fwq_if.sv */
`default_nettype none
interface fwq_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  futex_op;
    logic [3:0]  waiter_id;
    logic [63:0] addr;
    logic [31:0] value;
    logic [31:0] word_now;
    logic        word_ok;
    logic        timeout_fault;
    logic [31:0] match_mask;
    modport source(output valid, req_type, futex_op, waiter_id, addr, value, word_now,
                   word_ok, timeout_fault, match_mask, input ready);
    modport sink(input valid, req_type, futex_op, waiter_id, addr, value, word_now,
                 word_ok, timeout_fault, match_mask, output ready);
endinterface

interface fwq_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] target_id;
    logic [4:0] wake_count;
    logic       last;
    modport source(output valid, status, target_id, wake_count, last, input ready);
    modport sink(input valid, status, target_id, wake_count, last, output ready);
endinterface
`default_nettype wire

/* src/fwq_slot_ram.sv */
`default_nettype none
module fwq_slot_ram (
    input  wire logic                    i_clk,
    input  wire fwq_pkg::t_slot_wr       i_wr,
    input  wire logic                    i_re,
    input  wire logic [fwq_pkg::ID_W-1:0] i_raddr,
    output fwq_pkg::t_slot_rd            o_rd
);
    import fwq_pkg::*;

    logic [95:0]       r_data [WAITERS];
    logic [LINK_W-1:0] r_link [WAITERS];
    t_slot_rd          r_rd;

    // address and mask written on queueing, link also on unlink
    always_ff @(posedge i_clk) begin
        if (i_wr.we_full) begin
            r_data[i_wr.idx] <= {i_wr.address, i_wr.mask};
        end
        if (i_wr.we_full || i_wr.we_link) begin
            r_link[i_wr.idx] <= i_wr.link;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd <= {r_data[i_raddr], r_link[i_raddr]};
        end
    end

    assign o_rd = r_rd;
endmodule
`default_nettype wire

/* src/fwq_bucket_ram.sv */
`default_nettype none
module fwq_bucket_ram (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire fwq_pkg::t_bkt_wr          i_wr,
    input  wire logic                      i_re,
    input  wire logic [fwq_pkg::BKT_W-1:0] i_raddr,
    output logic [fwq_pkg::LINK_W-1:0]     o_head
);
    import fwq_pkg::*;

    logic [LINK_W-1:0] r_mem [BUCKETS];
    logic [BUCKETS-1:0] r_vld;
    logic [LINK_W-1:0] r_rd;
    logic              r_rd_vld;

    // head storage
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.idx] <= i_wr.head;
        end
        if (i_re) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    // written marks, an unwritten bucket reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_vld[i_wr.idx] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_head = r_rd_vld ? r_rd : EMPTY;
endmodule
`default_nettype wire

/* src/futex_wait_queue_table_unit.sv */
`default_nettype none
// channel | direction | contents
// i_req   | in        | req_type futex_op waiter_id addr value word_now word_ok
//         |           | timeout_fault match_mask
// o_res   | out       | status target_id wake_count last
//
// Wait, invalid and unknown ops need no list walk. A wake or a timeout
// walks its bucket list in the slot memory, reading and then checking one
// entry at a time, for at most WAITERS entries.
// Reset clears the busy flags and the bucket marks at once; no sweep.
// A stalled output holds the walk; a new item is taken once all results
// of the current one are in the output register.
module futex_wait_queue_table_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fwq_req_if.sink   i_req,
    fwq_res_if.source o_res
);
    import fwq_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_T_RD  = 10'b0000000010,
        S_T_ADR = 10'b0000000100,
        S_W_RD  = 10'b0000001000,
        S_W_WR  = 10'b0000010000,
        S_H_RD  = 10'b0000100000,
        S_H_CHK = 10'b0001000000,
        S_S_RD  = 10'b0010000000,
        S_S_CHK = 10'b0100000000,
        S_FINAL = 10'b1000000000
    } t_state;

    t_state             r_state, n_state;
    logic [WAITERS-1:0] r_busy, n_busy;
    logic               r_tmo, n_tmo;
    logic [ID_W-1:0]    r_id, n_id;
    logic [63:0]        r_a, n_a;
    logic [31:0]        r_val, n_val;
    logic [31:0]        r_mask, n_mask;
    logic [BKT_W-1:0]   r_b, n_b;
    logic [LINK_W-1:0]  r_cur, n_cur;
    logic [LINK_W-1:0]  r_prev, n_prev;
    logic [LINK_W-1:0]  r_steps, n_steps;
    logic [4:0]         r_woken, n_woken;
    logic [2:0]         r_st, n_st;
    logic [4:0]         r_cnt, n_cnt;

    logic               r_ovld, n_ovld;
    logic [2:0]         r_ost, n_ost;
    logic [3:0]         r_otid, n_otid;
    logic [4:0]         r_ocnt, n_ocnt;
    logic               r_olast, n_olast;

    t_slot_wr          slot_wr;
    t_slot_rd          slot_rd;
    logic              slot_re;
    logic [ID_W-1:0]   slot_raddr;
    t_bkt_wr           bkt_wr;
    logic              bkt_re;
    logic [LINK_W-1:0] bkt_head;

    logic              out_free;
    logic              accept;
    logic [6:0]        cmd;
    logic [31:0]       in_mask;
    logic              hit;
    logic              walk_end;

    fwq_slot_ram u_slot (
        .i_clk   (i_clk),
        .i_wr    (slot_wr),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rd    (slot_rd)
    );

    fwq_bucket_ram u_bkt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (bkt_wr),
        .i_re    (bkt_re),
        .i_raddr (r_b),
        .o_head  (bkt_head)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_ovld || o_res.ready;
    assign cmd         = i_req.futex_op[6:0] & OP_MASK;
    assign in_mask     = (cmd == OP_WAIT || cmd == OP_WAKE) ? MATCH_ANY : i_req.match_mask;

    // entry match: own slot for a timeout, address and mask for a wake
    assign hit = r_tmo ? (r_cur == {1'b0, r_id})
                       : ((slot_rd.address == r_a) && ((slot_rd.mask & r_mask) != '0));
    assign walk_end = (r_cur == EMPTY) || (r_steps == LINK_W'(WAITERS))
                      || (!r_tmo && ({27'd0, r_woken} >= r_val));

    // sequencer
    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_tmo   = r_tmo;
        n_id    = r_id;
        n_a     = r_a;
        n_val   = r_val;
        n_mask  = r_mask;
        n_b     = r_b;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_steps = r_steps;
        n_woken = r_woken;
        n_st    = r_st;
        n_cnt   = r_cnt;
        n_ovld  = r_ovld && !o_res.ready;
        n_ost   = r_ost;
        n_otid  = r_otid;
        n_ocnt  = r_ocnt;
        n_olast = r_olast;
        slot_wr = '0;
        slot_re = 1'b0;
        slot_raddr = r_id;
        bkt_wr  = '0;
        bkt_re  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_tmo   = i_req.req_type;
                    n_id    = i_req.waiter_id;
                    n_a     = i_req.addr;
                    n_val   = i_req.value;
                    n_mask  = in_mask;
                    n_b     = bucket_of(i_req.addr);
                    n_cnt   = '0;
                    n_woken = '0;
                    n_state = S_FINAL;
                    if (i_req.req_type) begin
                        if (r_busy[i_req.waiter_id]) begin
                            n_state = S_T_RD;
                        end else begin
                            n_st = ST_INVALID;
                        end
                    end else if (cmd == OP_WAIT || cmd == OP_WAIT_MASKED) begin
                        if (r_busy[i_req.waiter_id]) begin
                            n_st = ST_BUSY;
                        end else if (in_mask == '0) begin
                            n_st = ST_INVALID;
                        end else if (i_req.timeout_fault || !i_req.word_ok) begin
                            n_st = ST_FAULT;
                        end else if (i_req.word_now != i_req.value) begin
                            n_st = ST_AGAIN;
                        end else begin
                            n_state = S_W_RD;
                        end
                    end else if (cmd == OP_WAKE || cmd == OP_WAKE_MASKED) begin
                        if (in_mask == '0) begin
                            n_st = ST_INVALID;
                        end else begin
                            n_state = S_H_RD;
                        end
                    end else begin
                        n_st = ST_NOSYS;
                    end
                end
            end
            // timeout: fetch the waiter's address to find its bucket
            S_T_RD: begin
                slot_re = 1'b1;
                n_state = S_T_ADR;
            end
            S_T_ADR: begin
                n_b     = bucket_of(slot_rd.address);
                n_state = S_H_RD;
            end
            // wait: push the waiter at the head of its bucket
            S_W_RD: begin
                bkt_re  = 1'b1;
                n_state = S_W_WR;
            end
            S_W_WR: begin
                slot_wr.we_full = 1'b1;
                slot_wr.idx     = r_id;
                slot_wr.address = r_a;
                slot_wr.mask    = r_mask;
                slot_wr.link    = bkt_head;
                bkt_wr.we       = 1'b1;
                bkt_wr.idx      = r_b;
                bkt_wr.head     = {1'b0, r_id};
                n_busy[r_id]    = 1'b1;
                n_st            = ST_QUEUED;
                n_state         = S_FINAL;
            end
            // list walk
            S_H_RD: begin
                bkt_re  = 1'b1;
                n_prev  = EMPTY;
                n_steps = '0;
                n_state = S_H_CHK;
            end
            S_H_CHK: begin
                n_cur   = bkt_head;
                n_state = S_S_RD;
            end
            S_S_RD: begin
                if (walk_end) begin
                    n_state = S_FINAL;
                    if (r_tmo) begin
                        n_busy[r_id] = 1'b0;
                        n_st         = ST_TIMEDOUT;
                    end else begin
                        n_st  = ST_OK;
                        n_cnt = r_woken;
                    end
                end else begin
                    slot_re    = 1'b1;
                    slot_raddr = r_cur[ID_W-1:0];
                    n_state    = S_S_CHK;
                end
            end
            S_S_CHK: begin
                if (!hit) begin
                    n_prev  = r_cur;
                    n_cur   = slot_rd.link;
                    n_steps = r_steps + 1'b1;
                    n_state = S_S_RD;
                end else if (r_tmo || out_free) begin
                    // unlink the entry
                    if (r_prev == EMPTY) begin
                        bkt_wr.we   = 1'b1;
                        bkt_wr.idx  = r_b;
                        bkt_wr.head = slot_rd.link;
                    end else begin
                        slot_wr.we_link = 1'b1;
                        slot_wr.idx     = r_prev[ID_W-1:0];
                        slot_wr.link    = slot_rd.link;
                    end
                    n_busy[r_cur[ID_W-1:0]] = 1'b0;
                    if (r_tmo) begin
                        n_st    = ST_TIMEDOUT;
                        n_state = S_FINAL;
                    end else begin
                        n_ovld  = 1'b1;
                        n_ost   = ST_OK;
                        n_otid  = r_cur[ID_W-1:0];
                        n_ocnt  = '0;
                        n_olast = 1'b0;
                        n_woken = r_woken + 1'b1;
                        n_cur   = slot_rd.link;
                        n_steps = r_steps + 1'b1;
                        n_state = S_S_RD;
                    end
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_ost   = r_st;
                    n_otid  = r_id;
                    n_ocnt  = r_cnt;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_ovld  <= n_ovld;
        end
    end

    // working and output payload
    always_ff @(posedge i_clk) begin
        r_tmo   <= n_tmo;
        r_id    <= n_id;
        r_a     <= n_a;
        r_val   <= n_val;
        r_mask  <= n_mask;
        r_b     <= n_b;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_steps <= n_steps;
        r_woken <= n_woken;
        r_st    <= n_st;
        r_cnt   <= n_cnt;
        r_ost   <= n_ost;
        r_otid  <= n_otid;
        r_ocnt  <= n_ocnt;
        r_olast <= n_olast;
    end

    assign o_res.valid      = r_ovld;
    assign o_res.status     = r_ost;
    assign o_res.target_id  = r_otid;
    assign o_res.wake_count = r_ocnt;
    assign o_res.last       = r_olast;
endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import fwq_pkg::*;

    logic i_clk;
    logic i_rst_n;

    fwq_req_if req_bus();
    fwq_res_if res_bus();

    futex_wait_queue_table_unit uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus.sink),
        .o_res  (res_bus.source)
    );

    // one result of the table
    typedef struct packed {
        logic [2:0] status;
        logic [3:0] target_id;
        logic [4:0] wake_count;
        logic       last;
    } t_futex_res;

    // one request item
    typedef struct packed {
        logic        req_type;
        logic [7:0]  futex_op;
        logic [3:0]  waiter_id;
        logic [63:0] addr;
        logic [31:0] value;
        logic [31:0] word_now;
        logic        word_ok;
        logic        timeout_fault;
        logic [31:0] match_mask;
    } t_futex_req;

    // directed row: request plus an optional typed-in result
    typedef struct {
        t_futex_req req;
        bit         has_res;
        t_futex_res res;
    } t_row;

    // shadow wait-queue table
    bit                q_busy   [WAITERS];
    logic [63:0]       q_addr   [WAITERS];
    logic [31:0]       q_mask   [WAITERS];
    logic [LINK_W-1:0] q_link   [WAITERS];
    logic [LINK_W-1:0] q_head   [BUCKETS];

    t_futex_res pending_res[$];
    int         fail_cnt;
    logic [63:0] addr_pool[4];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #20ms;
        $display("[futex_wait_queue_table_unit] ERROR");
        $finish;
    end

    function automatic int hash_bucket(logic [63:0] a);
        logic [31:0] h;
        h = 32'((a >> 2) ^ (a >> HASH_SHIFT));
        return int'(h % BUCKETS);
    endfunction

    task automatic table_clear();
        for (int i = 0; i < WAITERS; i++) begin
            q_busy[i] = 1'b0;
            q_link[i] = EMPTY;
        end
        for (int i = 0; i < BUCKETS; i++) q_head[i] = EMPTY;
    endtask

    task automatic push_res(logic [2:0] st, logic [3:0] id, logic [4:0] cnt, logic lst);
        t_futex_res r;
        r.status = st;
        r.target_id = id;
        r.wake_count = cnt;
        r.last = lst;
        pending_res.push_back(r);
    endtask

    // remove a waiter from its bucket list
    task automatic drop_waiter(int id);
        int b;
        int prev;
        int cur;
        b = hash_bucket(q_addr[id]);
        prev = WAITERS;
        cur = q_head[b];
        for (int s = 0; s < WAITERS && cur < WAITERS; s++) begin
            if (cur == id) begin
                if (prev == WAITERS) q_head[b] = q_link[cur];
                else q_link[prev] = q_link[cur];
                break;
            end
            prev = cur;
            cur = q_link[cur];
        end
        q_busy[id] = 1'b0;
    endtask

    // work out the results of one request and update the shadow table
    task automatic futex_predict(t_futex_req rq);
        logic [6:0]  cmd;
        logic [31:0] msk;
        logic [2:0]  st;
        int b;
        int prev;
        int cur;
        int nxt;
        int steps;
        int unsigned woken;
        cmd = rq.futex_op[6:0] & OP_MASK;
        if (rq.req_type) begin
            if (q_busy[rq.waiter_id]) begin
                drop_waiter(rq.waiter_id);
                push_res(ST_TIMEDOUT, rq.waiter_id, 5'd0, 1'b1);
            end else begin
                push_res(ST_INVALID, rq.waiter_id, 5'd0, 1'b1);
            end
        end else if (cmd == OP_WAIT || cmd == OP_WAIT_MASKED) begin
            msk = (cmd == OP_WAIT) ? MATCH_ANY : rq.match_mask;
            if (q_busy[rq.waiter_id]) st = ST_BUSY;
            else if (msk == 0) st = ST_INVALID;
            else if (rq.timeout_fault || !rq.word_ok) st = ST_FAULT;
            else if (rq.word_now != rq.value) st = ST_AGAIN;
            else begin
                b = hash_bucket(rq.addr);
                q_addr[rq.waiter_id] = rq.addr;
                q_mask[rq.waiter_id] = msk;
                q_link[rq.waiter_id] = q_head[b];
                q_head[b] = LINK_W'(rq.waiter_id);
                q_busy[rq.waiter_id] = 1'b1;
                st = ST_QUEUED;
            end
            push_res(st, rq.waiter_id, 5'd0, 1'b1);
        end else if (cmd == OP_WAKE || cmd == OP_WAKE_MASKED) begin
            msk = (cmd == OP_WAKE) ? MATCH_ANY : rq.match_mask;
            if (msk == 0) begin
                push_res(ST_INVALID, rq.waiter_id, 5'd0, 1'b1);
            end else begin
                b = hash_bucket(rq.addr);
                prev = WAITERS;
                cur = q_head[b];
                steps = 0;
                woken = 0;
                while (cur < WAITERS && steps < WAITERS && woken < rq.value) begin
                    nxt = q_link[cur];
                    if (q_addr[cur] == rq.addr && (q_mask[cur] & msk) != 0) begin
                        if (prev == WAITERS) q_head[b] = LINK_W'(nxt);
                        else q_link[prev] = LINK_W'(nxt);
                        q_busy[cur] = 1'b0;
                        push_res(ST_OK, 4'(cur), 5'd0, 1'b0);
                        woken++;
                    end else begin
                        prev = cur;
                    end
                    cur = nxt;
                    steps++;
                end
                push_res(ST_OK, rq.waiter_id, 5'(woken), 1'b1);
            end
        end else begin
            push_res(ST_NOSYS, rq.waiter_id, 5'd0, 1'b1);
        end
    endtask

    // send one item, waiting a random gap first; valid stays up after the
    // accepting edge so that a zero gap gives back-to-back items
    task automatic send_item(t_futex_req rq);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.req_type      <= rq.req_type;
        req_bus.futex_op      <= rq.futex_op;
        req_bus.waiter_id     <= rq.waiter_id;
        req_bus.addr          <= rq.addr;
        req_bus.value         <= rq.value;
        req_bus.word_now      <= rq.word_now;
        req_bus.word_ok       <= rq.word_ok;
        req_bus.timeout_fault <= rq.timeout_fault;
        req_bus.match_mask    <= rq.match_mask;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // drop valid after the last accepted item
    task automatic bus_idle();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_futex_req make_req(logic rt, logic [7:0] op, logic [3:0] id,
                                            logic [63:0] a, logic [31:0] v, logic [31:0] w,
                                            logic ok, logic tf, logic [31:0] mm);
        t_futex_req r;
        r.req_type = rt;
        r.futex_op = op;
        r.waiter_id = id;
        r.addr = a;
        r.value = v;
        r.word_now = w;
        r.word_ok = ok;
        r.timeout_fault = tf;
        r.match_mask = mm;
        return r;
    endfunction

    // random request, mostly well-formed waits and wakes on a few addresses
    function automatic t_futex_req rand_req();
        t_futex_req r;
        int pick;
        r.req_type = 1'b0;
        r.futex_op = {$urandom_range(0, 1) == 1 ? 1'b1 : 1'b0, 7'd0};
        r.waiter_id = 4'($urandom);
        r.addr = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : addr_pool[$urandom_range(0, 3)];
        r.value = $urandom;
        r.word_now = r.value;
        r.word_ok = 1'b1;
        r.timeout_fault = 1'b0;
        r.match_mask = ($urandom_range(0, 1) == 1) ? (32'h1 << $urandom_range(0, 31)) : $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 40) r.futex_op[6:0] = ($urandom_range(0, 1) == 1) ? OP_WAIT : OP_WAIT_MASKED;
        else if (pick < 70) begin
            r.futex_op[6:0] = ($urandom_range(0, 1) == 1) ? OP_WAKE : OP_WAKE_MASKED;
            r.value = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 5);
        end else if (pick < 82) r.req_type = 1'b1;
        else if (pick < 92) begin
            r.futex_op[6:0] = OP_WAIT_MASKED;
            r.word_ok = 1'($urandom);
            r.timeout_fault = 1'($urandom);
            r.word_now = $urandom_range(0, 1) ? r.value : $urandom;
            if ($urandom_range(0, 3) == 0) r.match_mask = 32'd0;
        end else begin
            r.futex_op[6:0] = 7'($urandom);
            r.word_ok = 1'($urandom);
            r.timeout_fault = 1'($urandom);
            r.word_now = $urandom;
        end
        return r;
    endfunction

    // result side: random stalls, compare with the oldest expectation
    initial begin
        t_futex_res got;
        t_futex_res want;
        res_bus.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 3) == 0)
                res_bus.ready <= 1'b0;
            else
                res_bus.ready <= 1'b1;
            @(posedge i_clk);
            if (res_bus.valid && res_bus.ready) begin
                got = {res_bus.status, res_bus.target_id, res_bus.wake_count, res_bus.last};
                if (pending_res.size() == 0) begin
                    $display("%0t unexpected result %p", $time, got);
                    fail_cnt++;
                end else begin
                    want = pending_res.pop_front();
                    if (got !== want) begin
                        $display("%0t mismatch expected %p actual %p", $time, want, got);
                        fail_cnt++;
                    end
                end
            end
            if ($urandom_range(0, 30) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(5, 30)) @(posedge i_clk);
            end
        end
    end

    // stimulus
    initial begin
        t_row rows[$];
        t_row row;
        t_futex_req rq;
        int waited;
        fail_cnt = 0;
        addr_pool[0] = 64'h0000_0000_0000_1000;
        addr_pool[1] = 64'h0000_0000_0000_1004;
        addr_pool[2] = 64'h0000_0000_0004_1000;
        addr_pool[3] = 64'hFFFF_FFFF_FFFF_FFFC;
        table_clear();
        i_rst_n = 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.req_type <= 1'b0;
        req_bus.futex_op <= 8'd0;
        req_bus.waiter_id <= 4'd0;
        req_bus.addr <= 64'd0;
        req_bus.value <= 32'd0;
        req_bus.word_now <= 32'd0;
        req_bus.word_ok <= 1'b0;
        req_bus.timeout_fault <= 1'b0;
        req_bus.match_mask <= 32'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        row.has_res = 1'b1;
        row.req = make_req(1, 8'd0, 4'd3, 64'd0, 0, 0, 1, 0, 0);
        row.res = {ST_INVALID, 4'd3, 5'd0, 1'b1}; rows.push_back(row);
        row.req = make_req(0, {1'b1, OP_WAKE}, 4'd15, '1, '1, 0, 1, 0, 0);
        row.res = {ST_OK, 4'd15, 5'd0, 1'b1}; rows.push_back(row);
        row.req = make_req(0, {1'b0, OP_WAKE_MASKED}, 4'd1, 64'h40, 1, 0, 1, 0, 0);
        row.res = {ST_INVALID, 4'd1, 5'd0, 1'b1}; rows.push_back(row);
        row.req = make_req(0, {1'b0, OP_WAIT_MASKED}, 4'd2, 64'h40, 5, 5, 1, 0, 0);
        row.res = {ST_INVALID, 4'd2, 5'd0, 1'b1}; rows.push_back(row);
        row.req = make_req(0, {1'b0, OP_WAIT}, 4'd2, 64'h40, 5, 5, 1, 1, 0);
        row.res = {ST_FAULT, 4'd2, 5'd0, 1'b1}; rows.push_back(row);
        row.req = make_req(0, {1'b0, OP_WAIT}, 4'd2, 64'h40, 5, 5, 0, 0, 0);
        row.res = {ST_FAULT, 4'd2, 5'd0, 1'b1}; rows.push_back(row);
        row.req = make_req(0, {1'b1, OP_WAIT}, 4'd2, 64'h40, 5, 6, 1, 0, 0);
        row.res = {ST_AGAIN, 4'd2, 5'd0, 1'b1}; rows.push_back(row);
        row.req = make_req(0, 8'hFF, 4'd7, '1, '1, '1, 1, 1, '1);
        row.res = {ST_NOSYS, 4'd7, 5'd0, 1'b1}; rows.push_back(row);
        row.req = make_req(0, {1'b0, OP_WAIT}, 4'd0, '1, '1, '1, 1, 0, 0);
        row.res = {ST_QUEUED, 4'd0, 5'd0, 1'b1}; rows.push_back(row);
        row.req = make_req(0, {1'b0, OP_WAIT}, 4'd0, '1, '1, '1, 1, 0, 0);
        row.res = {ST_BUSY, 4'd0, 5'd0, 1'b1}; rows.push_back(row);
        row.has_res = 1'b0;
        // fill one address with waiters 1 to 15, masked and plain
        for (int i = 1; i < 16; i++) begin
            row.req = make_req(0, {1'b0, (i % 2) ? OP_WAIT_MASKED : OP_WAIT}, 4'(i),
                               64'h1000, 7, 7, 1, 0, 32'h1 << i);
            rows.push_back(row);
        end
        row.req = make_req(1, 8'd0, 4'd0, 64'd0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.req = make_req(0, {1'b0, OP_WAKE_MASKED}, 4'd9, 64'h1000, 3, 0, 1, 0, 32'h0000_AAAA);
        rows.push_back(row);
        row.req = make_req(0, {1'b0, OP_WAKE}, 4'd8, 64'h1000, '1, 0, 1, 0, 0); rows.push_back(row);

        foreach (rows[i]) begin
            futex_predict(rows[i].req);
            if (rows[i].has_res && pending_res[$] !== rows[i].res) begin
                $display("%0t mismatch expected %p actual %p", $time, rows[i].res, pending_res[$]);
                fail_cnt++;
            end
            send_item(rows[i].req);
        end

        // random part
        for (int n = 0; n < 250; n++) begin
            rq = rand_req();
            futex_predict(rq);
            send_item(rq);
            if (n == 120) begin
                bus_idle();
                while (pending_res.size() != 0) @(posedge i_clk);
            end
        end
        bus_idle();

        waited = 0;
        while (pending_res.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (60) @(posedge i_clk);
        if (fail_cnt == 0 && pending_res.size() == 0)
            $display("[futex_wait_queue_table_unit] OK");
        else
            $display("[futex_wait_queue_table_unit] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
src/fwq_pkg.sv
src/fwq_if.sv
src/fwq_slot_ram.sv
src/fwq_bucket_ram.sv
src/futex_wait_queue_table_unit.sv
dv/tb_top.sv
